// File: rtl/blf_pkg.sv
// Shared types and constants for the box and label fusion block.
package blf_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BOX   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register indexes on the APB port (byte address 4*index)
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ENABLE     = 2'd2;
    localparam int         APB_AW         = 4;

    localparam logic [10:0] MAP_WIDTH_RST  = 11'd640;
    localparam logic [9:0]  MAP_HEIGHT_RST = 10'd384;

    // Detection classes with special handling
    localparam logic signed [7:0] CLS_RELABEL_103 = 8'sd3;
    localparam logic signed [7:0] CLS_CHECK_104   = 8'sd4;
    localparam logic signed [7:0] CLS_RELABEL_106 = 8'sd6;

    // Label values
    localparam logic [7:0] LBL_ZERO  = 8'd0;
    localparam logic [7:0] LBL_ONE   = 8'd1;
    localparam logic [7:0] LBL_TWO   = 8'd2;
    localparam logic [7:0] LBL_THREE = 8'd3;
    localparam logic [7:0] LBL_FIVE  = 8'd5;
    localparam logic [7:0] LBL_103   = 8'd103;
    localparam logic [7:0] LBL_104   = 8'd104;
    localparam logic [7:0] LBL_106   = 8'd106;
    localparam logic signed [8:0] LBL_CLASS_OFFSET = 9'sd100;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [7:0]         pixel_label;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic signed [7:0]  class_id;
    } in_t;

    typedef struct packed {
        logic       is_box_result;
        logic [7:0] read_label;
        logic       box_kept;
    } out_t;

    typedef struct packed {
        logic [10:0] map_width;
        logic [9:0]  map_height;
        logic        enable_other_classes;
    } cfg_t;

endpackage

// File: rtl/box_label_fusion.sv
// Top level of the box and label fusion block: label memory, sequencer, APB registers.
//
//  channel  | ports                         | beat
//  ---------+-------------------------------+--------------------------------------
//  input    | s_valid, s_ready, s_data      | pixel write, pixel read or box
//  result   | m_valid, m_ready, m_data      | read label or box kept flag
//  config   | psel..pready (APB)            | map width, map height, class enable
//
// A pixel write leaves the sequencer idle; a pixel read waits for the memory read,
// then for the result register. A box scans its clipped region through the label
// memory read port, one pixel per cycle, in one pass, or in two for a class 4 box
// that repaints. Empty boxes skip the scan. Reset is synchronous; the label memory
// is not cleared. A stalled result beat holds a finished read or box until the
// result register is free.
module box_label_fusion #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  blf_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output blf_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import blf_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    cfg_t          cfg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    blf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blf_mem #(
        .AW (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    blf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW),
        .YW         (YW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    a_read_not_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_box_result |-> !m_data.box_kept)
        else $error("read result flagged as kept box");

    a_box_no_label: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_box_result |-> m_data.read_label == LBL_ZERO)
        else $error("box result carries a label");

    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_WRITE |=> s_ready)
        else $error("pixel write held the input");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_READ |=> !s_ready)
        else $error("input taken while a pixel read waits for memory");

endmodule

// File: rtl/blf_cfg.sv
// APB configuration registers: map size and the other-class enable.
module blf_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output blf_pkg::cfg_t              cfg
);
    import blf_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_width            <= MAP_WIDTH_RST;
            cfg_reg.map_height           <= MAP_HEIGHT_RST;
            cfg_reg.enable_other_classes <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MAP_WIDTH:  cfg_reg.map_width            <= pwdata[10:0];
                REG_MAP_HEIGHT: cfg_reg.map_height           <= pwdata[9:0];
                REG_ENABLE:     cfg_reg.enable_other_classes <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAP_WIDTH:  prdata = 32'(cfg_reg.map_width);
            REG_MAP_HEIGHT: prdata = 32'(cfg_reg.map_height);
            REG_ENABLE:     prdata = 32'(cfg_reg.enable_other_classes);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/blf_mem.sv
// Label map storage: one write port, one read port with registered data.
module blf_mem #(
    parameter int AW = 19
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [2**AW];
    logic [7:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// File: rtl/blf_ctrl.sv
// Sequencer: pixel access, box clipping, region scans and the result register.
module blf_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int XW         = 10,
    parameter int YW         = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  blf_pkg::in_t       s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output blf_pkg::out_t      m_data,
    input  blf_pkg::cfg_t      cfg,
    output logic               mem_we,
    output logic [XW+YW-1:0]   mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic               mem_re,
    output logic [XW+YW-1:0]   mem_raddr,
    input  logic [7:0]         mem_rdata
);
    import blf_pkg::*;

    localparam int CW = XW + 1;
    localparam int RW = YW + 1;
    localparam int LW = (CW > 11) ? CW : 11;
    localparam int HW = (RW > 10) ? RW : 10;
    localparam int AW = XW + YW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_BSTART = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_DECIDE = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PASS_COUNT   = 2'd0,
        PASS_RELABEL = 2'd1,
        PASS_FILL    = 2'd2
    } pass_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;
    logic               inside_reg, inside_next;
    logic signed [17:0] bx1_reg, bx2_reg, by1_reg, by2_reg;
    logic signed [17:0] bx1_next, bx2_next, by1_next, by2_next;
    logic signed [7:0]  class_reg, class_next;
    logic [XW-1:0]      x1_reg, x1_next, xl_reg, xl_next, cx_reg, cx_next;
    logic [YW-1:0]      y1_reg, y1_next, yl_reg, yl_next, cy_reg, cy_next;
    pass_t              mode_reg, mode_next;
    logic [7:0]         val_reg, val_next;
    logic               kept_reg, kept_next;
    logic               any1_reg, any1_next, any23_reg, any23_next;
    logic               st_valid_reg, st_valid_next;
    logic [AW-1:0]      st_addr_reg, st_addr_next;

    logic [CW-1:0]      cols;
    logic [RW-1:0]      rows;
    logic               pix_in_map, accept, out_free, empty;
    logic [AW-1:0]      pix_addr;
    logic signed [17:0] cmax, rmax;
    logic signed [8:0]  id_sum;
    logic [7:0]         id_label;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        cols = (LW'(cfg.map_width) > LW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg.map_width);
        rows = (HW'(cfg.map_height) > HW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT)
                                                       : RW'(cfg.map_height);
        pix_in_map = (LW'(s_data.pixel_x) < LW'(cols)) && (HW'(s_data.pixel_y) < HW'(rows));
        pix_addr = {YW'(s_data.pixel_y), XW'(s_data.pixel_x)};
        cmax = $signed(18'(cols)) - 18'sd1;
        rmax = $signed(18'(rows)) - 18'sd1;
        empty = (bx1_reg >= bx2_reg) || (by1_reg >= by2_reg);
        id_sum = 9'(class_reg) + LBL_CLASS_OFFSET;
        id_label = (id_sum < 9'sd0) ? LBL_ZERO : id_sum[7:0];
    end

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        inside_next   = inside_reg;
        bx1_next      = bx1_reg;
        bx2_next      = bx2_reg;
        by1_next      = by1_reg;
        by2_next      = by2_reg;
        class_next    = class_reg;
        x1_next       = x1_reg;
        xl_next       = xl_reg;
        y1_next       = y1_reg;
        yl_next       = yl_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        mode_next     = mode_reg;
        val_next      = val_reg;
        kept_next     = kept_reg;
        any1_next     = any1_reg;
        any23_next    = any23_reg;
        st_valid_next = 1'b0;
        st_addr_next  = st_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = pix_addr;
        mem_wdata     = (s_data.pixel_label == LBL_ZERO) ? LBL_TWO : s_data.pixel_label;
        mem_re        = 1'b0;
        mem_raddr     = pix_addr;

        // modify and write back, or count, the pixel read in the previous cycle
        if (st_valid_reg) begin
            mem_waddr = st_addr_reg;
            mem_wdata = val_reg;
            case (mode_reg)
                PASS_FILL: mem_we = 1'b1;
                PASS_RELABEL: mem_we = (mem_rdata == LBL_ONE) || (mem_rdata == LBL_FIVE);
                PASS_COUNT: begin
                    if (mem_rdata == LBL_ONE) begin
                        any1_next = 1'b1;
                    end
                    if ((mem_rdata == LBL_TWO) || (mem_rdata == LBL_THREE)) begin
                        any23_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_WRITE) begin
                        mem_we = pix_in_map;
                    end else if (s_data.operation == OP_READ) begin
                        mem_re      = 1'b1;
                        inside_next = pix_in_map;
                        state_next  = ST_READ;
                    end else if (s_data.operation == OP_BOX) begin
                        bx1_next = (s_data.box_left > 16'sd0) ? 18'(s_data.box_left) : 18'sd0;
                        by1_next = (s_data.box_top > 16'sd0) ? 18'(s_data.box_top) : 18'sd0;
                        bx2_next = (18'(s_data.box_right) < cmax) ? 18'(s_data.box_right)
                                                                 : cmax;
                        by2_next = (18'(s_data.box_bottom) < rmax) ? 18'(s_data.box_bottom)
                                                                  : rmax;
                        class_next = s_data.class_id;
                        state_next = ST_BSTART;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.is_box_result = 1'b0;
                    m_data_next.read_label    = inside_reg ? mem_rdata : LBL_ZERO;
                    m_data_next.box_kept      = 1'b0;
                    state_next                = ST_IDLE;
                end
            end
            ST_BSTART: begin
                x1_next    = XW'(bx1_reg);
                y1_next    = YW'(by1_reg);
                xl_next    = XW'(bx2_reg - 18'sd1);
                yl_next    = YW'(by2_reg - 18'sd1);
                cx_next    = XW'(bx1_reg);
                cy_next    = YW'(by1_reg);
                any1_next  = 1'b0;
                any23_next = 1'b0;
                kept_next  = 1'b0;
                state_next = ST_SCAN;
                if (empty) begin
                    state_next = ST_DONE;
                end else if (class_reg == CLS_RELABEL_103) begin
                    mode_next = PASS_RELABEL;
                    val_next  = LBL_103;
                end else if (class_reg == CLS_RELABEL_106) begin
                    mode_next = PASS_RELABEL;
                    val_next  = LBL_106;
                end else if (class_reg == CLS_CHECK_104) begin
                    mode_next = PASS_COUNT;
                    val_next  = LBL_104;
                end else if (cfg.enable_other_classes) begin
                    mode_next = PASS_FILL;
                    val_next  = id_label;
                    kept_next = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                mem_re        = 1'b1;
                mem_raddr     = {cy_reg, cx_reg};
                st_valid_next = 1'b1;
                st_addr_next  = {cy_reg, cx_reg};
                if (cx_reg == xl_reg) begin
                    cx_next = x1_reg;
                    cy_next = cy_reg + YW'(1);
                    if (cy_reg == yl_reg) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    cx_next = cx_reg + XW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = (mode_reg == PASS_COUNT) ? ST_DECIDE : ST_DONE;
            end
            ST_DECIDE: begin
                cx_next    = x1_reg;
                cy_next    = y1_reg;
                kept_next  = 1'b1;
                state_next = ST_SCAN;
                if (!any1_reg && any23_reg) begin
                    mode_next = PASS_FILL;
                end else if (!any23_reg) begin
                    mode_next = PASS_RELABEL;
                end else begin
                    kept_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.is_box_result = 1'b1;
                    m_data_next.read_label    = LBL_ZERO;
                    m_data_next.box_kept      = kept_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        inside_reg  <= inside_next;
        bx1_reg     <= bx1_next;
        bx2_reg     <= bx2_next;
        by1_reg     <= by1_next;
        by2_reg     <= by2_next;
        class_reg   <= class_next;
        x1_reg      <= x1_next;
        xl_reg      <= xl_next;
        y1_reg      <= y1_next;
        yl_reg      <= yl_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        mode_reg    <= mode_next;
        val_reg     <= val_next;
        kept_reg    <= kept_next;
        any1_reg    <= any1_next;
        any23_reg   <= any23_next;
        st_addr_reg <= st_addr_next;
    end

endmodule

// File: bench/label_fusion_checker.sv
// Scoreboard for the box and label fusion block: shadows the map, predicts and compares.
`timescale 1ns / 1ps
module label_fusion_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  blf_pkg::in_t                s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  blf_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          results_seen,
    output int                          kept_boxes,
    output int                          results_pending
);
    import blf_pkg::*;

    bit [7:0]    shadow_map [MAX_WIDTH*MAX_HEIGHT];
    logic [10:0] cols_cfg;
    logic [9:0]  rows_cfg;
    logic        paint_others;
    out_t        expected_q[$];

    function automatic int cols_used();
        return (cols_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_cfg);
    endfunction

    function automatic int rows_used();
        return (rows_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_cfg);
    endfunction

    function automatic int map_index(int x, int y);
        return y * MAX_WIDTH + x;
    endfunction

    // fill sets every pixel; otherwise only labels 1 and 5 take the new value
    function automatic void repaint(int x0, int y0, int x1, int y1, logic [7:0] val, bit fill);
        for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++)
                if (fill || shadow_map[map_index(x, y)] == LBL_ONE ||
                    shadow_map[map_index(x, y)] == LBL_FIVE)
                    shadow_map[map_index(x, y)] = val;
    endfunction

    // Clip the box, update the map and return the kept flag
    function automatic logic fuse_box(in_t b);
        int x0, y0, x1, y1, cls, ones, twos_threes, lbl;
        logic [7:0] v;
        cls = b.class_id;
        x0 = b.box_left;
        y0 = b.box_top;
        x1 = b.box_right;
        y1 = b.box_bottom;
        ones = 0;
        twos_threes = 0;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > cols_used() - 1) x1 = cols_used() - 1;
        if (y1 > rows_used() - 1) y1 = rows_used() - 1;
        if (x0 >= x1 || y0 >= y1) return 1'b0;
        if (cls == CLS_RELABEL_103) begin
            repaint(x0, y0, x1, y1, LBL_103, 1'b0);
            return 1'b0;
        end
        if (cls == CLS_RELABEL_106) begin
            repaint(x0, y0, x1, y1, LBL_106, 1'b0);
            return 1'b0;
        end
        if (cls == CLS_CHECK_104) begin
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++) begin
                    v = shadow_map[map_index(x, y)];
                    if (v == LBL_ONE) ones++;
                    else if (v == LBL_TWO || v == LBL_THREE) twos_threes++;
                end
            if (ones == 0 && twos_threes > 0) begin
                repaint(x0, y0, x1, y1, LBL_104, 1'b1);
                return 1'b1;
            end
            if (twos_threes == 0) begin
                repaint(x0, y0, x1, y1, LBL_104, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (!paint_others) return 1'b0;
        lbl = cls + LBL_CLASS_OFFSET;
        if (lbl < 0) lbl = 0;
        if (lbl > 255) lbl = 255;
        repaint(x0, y0, x1, y1, 8'(lbl), 1'b1);
        return 1'b1;
    endfunction

    task automatic take_beat(input in_t b);
        out_t res;
        bit   in_map;
        res = '0;
        in_map = (int'(b.pixel_x) < cols_used()) && (int'(b.pixel_y) < rows_used());
        case (b.operation)
            OP_WRITE: begin
                if (in_map)
                    shadow_map[map_index(b.pixel_x, b.pixel_y)] =
                        (b.pixel_label == LBL_ZERO) ? LBL_TWO : b.pixel_label;
            end
            OP_BOX: begin
                res.is_box_result = 1'b1;
                res.box_kept = fuse_box(b);
                expected_q.insert(expected_q.size(), res);
            end
            OP_READ: begin
                res.read_label = in_map ? shadow_map[map_index(b.pixel_x, b.pixel_y)] : LBL_ZERO;
                expected_q.insert(expected_q.size(), res);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        // stay quiet after the first hundred, but keep counting
        if (mismatches < 100) $display("%0t ns ERROR %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        out_t        got;
        out_t        want;
        logic [31:0] reg_val;
        if (!aresetn) begin
            cols_cfg = MAP_WIDTH_RST;
            rows_cfg = MAP_HEIGHT_RST;
            paint_others = 1'b1;
            expected_q.delete();
        end else begin
            // retire the result beat before queueing anything accepted this edge
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %b with nothing outstanding", got));
                end else begin
                    want = expected_q.pop_front();
                    results_seen++;
                    if (want.box_kept) kept_boxes++;
                    check_field("is_box_result", 32'(got.is_box_result),
                                32'(want.is_box_result));
                    check_field("read_label", 32'(got.read_label), 32'(want.read_label));
                    check_field("box_kept", 32'(got.box_kept), 32'(want.box_kept));
                end
            end
            if (s_valid && s_ready) take_beat(s_data);
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_AW-1:2])
                        REG_MAP_WIDTH:  cols_cfg = pwdata[10:0];
                        REG_MAP_HEIGHT: rows_cfg = pwdata[9:0];
                        REG_ENABLE:     paint_others = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    reg_val = prdata;
                    case (paddr[APB_AW-1:2])
                        REG_MAP_WIDTH:  reg_val = 32'(cols_cfg);
                        REG_MAP_HEIGHT: reg_val = 32'(rows_cfg);
                        REG_ENABLE:     reg_val = 32'(paint_others);
                        default: ;
                    endcase
                    check_field("prdata", prdata, reg_val);
                end
            end
        end
        results_pending = expected_q.size();
    end

endmodule

// File: bench/tb_top.sv
// Stimulus and verdict for the box and label fusion block.
`timescale 1ns / 1ps
module tb_top;
    import blf_pkg::*;

    localparam int         MAX_WIDTH    = 1024;
    localparam int         MAX_HEIGHT   = 512;
    localparam logic [1:0] OP_NONE      = 2'd3;   // undefined operation, no result
    localparam int         IDLE_PCT     = 28;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         QUIET_CYCLES = 12;
    localparam int         BEAT_TARGET  = 1750;

    typedef enum int {PAL_NO_TWOS, PAL_NO_ONES, PAL_MIXED} palette_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    in_t                 s_data  = '0;
    logic                m_ready = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic                s_ready;
    logic                m_valid;
    out_t                m_data;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches;
    int results_seen;
    int kept_boxes;
    int results_pending;
    int beats_sent    = 0;
    int settings_used = 0;
    bit idle_en       = 1'b1;
    bit hold_req      = 1'b0;

    logic [1:0] reg_list [3] = '{REG_MAP_WIDTH, REG_MAP_HEIGHT, REG_ENABLE};

    always #2 aclk = ~aclk;

    box_label_fusion #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    label_fusion_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_seen    (results_seen),
        .kept_boxes      (kept_boxes),
        .results_pending (results_pending)
    );

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still outstanding", results_pending);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic in_t random_beat();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return noise[$bits(in_t)-1:0];
    endfunction

    function automatic in_t pixel_beat(logic [1:0] op, int x, int y, logic [7:0] lbl);
        in_t beat;
        beat = random_beat();
        beat.operation   = op;
        beat.pixel_x     = 10'(x);
        beat.pixel_y     = 9'(y);
        beat.pixel_label = lbl;
        return beat;
    endfunction

    function automatic in_t box_beat(int l, int t, int r, int b, int cls);
        in_t beat;
        beat = random_beat();
        beat.operation  = OP_BOX;
        beat.box_left   = 16'(l);
        beat.box_top    = 16'(t);
        beat.box_right  = 16'(r);
        beat.box_bottom = 16'(b);
        beat.class_id   = 8'(cls);
        return beat;
    endfunction

    function automatic logic [7:0] pick_label(palette_t pal);
        case (pal)
            PAL_NO_TWOS: begin
                case ($urandom_range(0, 2))
                    0: return LBL_ONE;
                    1: return LBL_FIVE;
                    default: return 8'($urandom_range(6, 255));
                endcase
            end
            PAL_NO_ONES: begin
                case ($urandom_range(0, 3))
                    0: return LBL_ZERO;
                    1: return LBL_TWO;
                    2: return LBL_THREE;
                    default: return 8'($urandom_range(4, 255));
                endcase
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return LBL_ONE;
                    1: return LBL_TWO;
                    2: return LBL_FIVE;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    task automatic push_beat(input in_t beat);
        @(negedge aclk);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Drop valid, wait for every result, then let a trailing pixel write finish
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_map(input int w, input int h, input bit en);
        wait_idle();
        apb_access(1'b1, REG_MAP_WIDTH, 32'(w));
        apb_access(1'b1, REG_MAP_HEIGHT, 32'(h));
        apb_access(1'b1, REG_ENABLE, 32'(en));
        foreach (reg_list[i]) apb_access(1'b0, reg_list[i], '0);
        settings_used++;
    endtask

    task automatic run_random_phase(input int phase);
        int       w, h, ops, l, t, r, b, cls, kind;
        palette_t pal;
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 12);
        set_map(w, h, $urandom_range(0, 3) != 0);
        idle_en = (phase != 1);
        pal = palette_t'($urandom_range(0, 2));
        // load the whole map so that every read and box sees written pixels
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                push_beat(pixel_beat(OP_WRITE, x, y, pick_label(pal)));
        ops = $urandom_range(120, 180);
        for (int i = 0; i < ops; i++) begin
            if (phase == 3 && i == 20) hold_req = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 38) begin
                case ($urandom_range(0, 9))
                    0: begin
                        l = $urandom;
                        t = $urandom;
                        r = $urandom;
                        b = $urandom;
                    end
                    1: begin
                        l = -int'($urandom_range(0, 3));
                        t = -int'($urandom_range(0, 3));
                        r = w - 1 + $urandom_range(0, 3);
                        b = h - 1 + $urandom_range(0, 3);
                    end
                    default: begin
                        l = int'($urandom_range(0, w + 2)) - 2;
                        t = int'($urandom_range(0, h + 2)) - 2;
                        r = l + $urandom_range(0, 6);
                        b = t + $urandom_range(0, 5);
                    end
                endcase
                if ($urandom_range(0, 9) < 7) begin
                    case ($urandom_range(0, 2))
                        0: cls = CLS_RELABEL_103;
                        1: cls = CLS_CHECK_104;
                        default: cls = CLS_RELABEL_106;
                    endcase
                end else begin
                    cls = $urandom_range(0, 255);
                end
                push_beat(box_beat(l, t, r, b, cls));
            end else if (kind < 70) begin
                if ($urandom_range(0, 4) == 0)
                    push_beat(pixel_beat(OP_READ, $urandom, $urandom, 8'($urandom)));
                else
                    push_beat(pixel_beat(OP_READ, $urandom_range(0, w - 1),
                                         $urandom_range(0, h - 1), 8'($urandom)));
            end else if (kind < 96) begin
                if ($urandom_range(0, 4) == 0)
                    push_beat(pixel_beat(OP_WRITE, $urandom, $urandom, pick_label(pal)));
                else
                    push_beat(pixel_beat(OP_WRITE, $urandom_range(0, w - 1),
                                         $urandom_range(0, h - 1), pick_label(pal)));
            end else begin
                push_beat(pixel_beat(OP_NONE, $urandom, $urandom, 8'($urandom)));
            end
        end
    endtask

    initial begin
        int phase;
        phase = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (reg_list[i]) apb_access(1'b0, reg_list[i], '0);

        // Full-size map: far corner and origin, zero label stored as two
        set_map(1024, 512, 1'b1);
        push_beat(pixel_beat(OP_WRITE, 1023, 511, 8'hFF));
        push_beat(pixel_beat(OP_WRITE, 0, 0, LBL_ZERO));
        push_beat(pixel_beat(OP_READ, 1023, 511, 8'h00));
        push_beat(pixel_beat(OP_READ, 0, 0, 8'h00));

        // Size registers beyond the store are limited to it
        set_map(2047, 1023, 1'b1);
        push_beat(pixel_beat(OP_READ, 1023, 511, 8'h00));
        push_beat(box_beat(-32768, -32768, 1, 1, 127));
        push_beat(pixel_beat(OP_READ, 0, 0, 8'h00));

        // Zero-size map: writes dropped, reads return zero, boxes empty
        set_map(0, 0, 1'b1);
        push_beat(pixel_beat(OP_WRITE, 0, 0, 8'd9));
        push_beat(pixel_beat(OP_READ, 0, 0, 8'h00));
        push_beat(box_beat(-32768, -32768, 32767, 32767, -128));

        // Small map with striped labels: ones, zeros, fives
        set_map(6, 5, 1'b0);
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 6; x++)
                push_beat(pixel_beat(OP_WRITE, x, y,
                                     (x < 2) ? LBL_ONE : (x < 4) ? LBL_ZERO : LBL_FIVE));
        push_beat(box_beat(4, 0, 6, 4, CLS_CHECK_104));        // no twos: relabel
        push_beat(box_beat(0, 0, 3, 2, CLS_CHECK_104));        // both present: untouched
        push_beat(box_beat(2, -5, 4, 9, CLS_CHECK_104));       // no ones: fill
        push_beat(box_beat(-32768, -32768, 32767, 32767, CLS_RELABEL_103));
        push_beat(pixel_beat(OP_WRITE, 1, 1, LBL_FIVE));
        push_beat(pixel_beat(OP_WRITE, 0, 2, LBL_ONE));
        push_beat(box_beat(0, 0, 2, 3, CLS_RELABEL_106));
        push_beat(box_beat(0, 0, 5, 4, 7));                    // other class, disabled
        push_beat(box_beat(3, 0, 3, 4, CLS_CHECK_104));        // empty in x
        push_beat(box_beat(0, 2, 5, 2, CLS_RELABEL_103));      // empty in y
        push_beat(pixel_beat(OP_READ, 1, 1, 8'h00));
        push_beat(pixel_beat(OP_READ, 4, 4, 8'h00));
        push_beat(pixel_beat(OP_NONE, 5, 0, 8'h00));

        // Other classes painting, with saturation at zero
        set_map(6, 5, 1'b1);
        push_beat(box_beat(0, 0, 2, 2, -128));
        push_beat(box_beat(2, 2, 5, 4, 127));
        push_beat(box_beat(0, 0, 1, 4, -100));
        push_beat(box_beat(4, 0, 5, 1, 0));
        push_beat(pixel_beat(OP_READ, 0, 0, 8'h00));
        push_beat(pixel_beat(OP_READ, 3, 3, 8'h00));

        while (beats_sent < BEAT_TARGET) begin
            run_random_phase(phase);
            phase++;
        end
        idle_en = 1'b1;
        wait_idle();

        $display("Sent %0d input beats over %0d map settings, including empty and clipped boxes",
                 beats_sent, settings_used);
        $display("Compared %0d results, %0d of them kept boxes", results_seen, kept_boxes);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
